// File: design/pwq_pkg.sv
package pwq_pkg;

  // default store depth
  localparam int QUEUE_DEPTH_DEF = 16;

  // action codes
  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_POP  = 1'b1;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // input word
  typedef struct packed {
    logic        action;
    logic [7:0]  job_priority;
    logic [15:0] job_handle;
    logic [15:0] job_length;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] out_handle;
    logic [15:0] out_length;
    logic [7:0]  out_priority;
    logic [4:0]  pending_count;
  } out_word_t;

  // one stored job
  typedef struct packed {
    logic [7:0]  prio;
    logic [15:0] handle;
    logic [15:0] length;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// File: design/pwq_ram.sv
module pwq_ram #(
  parameter int WIDTH = pwq_pkg::ENTRY_W,
  parameter int DEPTH = pwq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: design/priority_work_queue.sv
// channel   ports                          word
// ------    -----------------------------  ----------------------
// input     in_valid  in_ready  in_data    pwq_pkg::in_word_t
// result    out_valid out_ready out_data   pwq_pkg::out_word_t
//
// one word is in flight at a time; a push or an empty-queue pop goes from idle
// straight to done. a pop of a non-empty queue scans every job, with
// one store read per cycle while scanning, then one read and one write per
// cycle while the jobs after the winner move down.
// synchronous active-low reset empties the queue; the job store needs no clear.
// a result that waits on out_ready holds the block in its final state.
module priority_work_queue #(
  parameter int QUEUE_DEPTH = pwq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  pwq_pkg::in_word_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output pwq_pkg::out_word_t  out_data
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_SHIFT = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t              state_r, state_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [AW-1:0]       rd_idx_r, rd_idx_nxt;
  logic [AW-1:0]       best_idx_r, best_idx_nxt;
  pwq_pkg::entry_t     best_r, best_nxt;
  pwq_pkg::out_word_t  res_r, res_nxt;
  pwq_pkg::out_word_t  out_data_r, out_data_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic                ram_wr_en;
  logic [AW-1:0]       ram_wr_addr;
  pwq_pkg::entry_t     ram_wr_data;
  logic                ram_rd_en;
  logic [AW-1:0]       ram_rd_addr;
  pwq_pkg::entry_t     ram_rd_data;

  logic                rd_last;
  logic                take_new;
  logic [AW-1:0]       scan_best_idx;
  pwq_pkg::entry_t     scan_best;
  pwq_pkg::entry_t     push_entry;

  // job store; scan and move-down never touch the same entry in one cycle
  pwq_ram #(
    .WIDTH (pwq_pkg::ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign push_entry.prio   = in_data.job_priority;
  assign push_entry.handle = in_data.job_handle;
  assign push_entry.length = in_data.job_length;

  // data on the read port belongs to the last live entry
  assign rd_last = ((CW'(rd_idx_r) + CW'(1)) == count_r);

  // running maximum, earliest arrival kept on ties
  assign take_new      = (rd_idx_r == '0) || (ram_rd_data.prio > best_r.prio);
  assign scan_best_idx = take_new ? rd_idx_r : best_idx_r;
  assign scan_best     = take_new ? ram_rd_data : best_r;

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    rd_idx_nxt   = rd_idx_r;
    best_idx_nxt = best_idx_r;
    best_nxt     = best_r;
    res_nxt      = res_r;
    out_data_nxt = out_data_r;
    ram_wr_en    = 1'b0;
    ram_wr_addr  = '0;
    ram_wr_data  = push_entry;
    ram_rd_en    = 1'b0;
    ram_rd_addr  = '0;

    out_valid_nxt = out_valid_r && !out_ready;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          res_nxt = '0;
          if (in_data.action == pwq_pkg::ACT_PUSH) begin
            if (count_r == CW'(QUEUE_DEPTH)) begin
              res_nxt.status        = pwq_pkg::ST_FULL;
              res_nxt.pending_count = 5'(count_r);
            end else begin
              ram_wr_en             = 1'b1;
              ram_wr_addr           = AW'(count_r);
              count_nxt             = count_r + CW'(1);
              res_nxt.status        = pwq_pkg::ST_OK;
              res_nxt.pending_count = 5'(count_r + CW'(1));
            end
            state_nxt = S_DONE;
          end else if (count_r == '0) begin
            res_nxt.status        = pwq_pkg::ST_EMPTY;
            res_nxt.pending_count = 5'(count_r);
            state_nxt             = S_DONE;
          end else begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = '0;
            rd_idx_nxt  = '0;
            state_nxt   = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        best_nxt     = scan_best;
        best_idx_nxt = scan_best_idx;
        if (!rd_last) begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = rd_idx_r + AW'(1);
          rd_idx_nxt  = rd_idx_r + AW'(1);
        end else if ((CW'(scan_best_idx) + CW'(1)) < count_r) begin
          // later jobs move down one place
          ram_rd_en   = 1'b1;
          ram_rd_addr = scan_best_idx + AW'(1);
          rd_idx_nxt  = scan_best_idx + AW'(1);
          state_nxt   = S_SHIFT;
        end else begin
          count_nxt             = count_r - CW'(1);
          res_nxt.status        = pwq_pkg::ST_OK;
          res_nxt.out_handle    = scan_best.handle;
          res_nxt.out_length    = scan_best.length;
          res_nxt.out_priority  = scan_best.prio;
          res_nxt.pending_count = 5'(count_r - CW'(1));
          state_nxt             = S_DONE;
        end
      end

      S_SHIFT: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = rd_idx_r - AW'(1);
        ram_wr_data = ram_rd_data;
        if (!rd_last) begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = rd_idx_r + AW'(1);
          rd_idx_nxt  = rd_idx_r + AW'(1);
        end else begin
          count_nxt             = count_r - CW'(1);
          res_nxt.status        = pwq_pkg::ST_OK;
          res_nxt.out_handle    = best_r.handle;
          res_nxt.out_length    = best_r.length;
          res_nxt.out_priority  = best_r.prio;
          res_nxt.pending_count = 5'(count_r - CW'(1));
          state_nxt             = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_data_nxt  = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rd_idx_r   <= rd_idx_nxt;
    best_idx_r <= best_idx_nxt;
    best_r     <= best_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// File: tb/tb_top.sv
module tb_top;

  localparam int DEPTH       = pwq_pkg::QUEUE_DEPTH_DEF;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_WAIT  = 2 * DEPTH + 8;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  pwq_pkg::in_word_t  in_data   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  pwq_pkg::out_word_t out_data;

  // idling switches and the long receiver hold-off
  bit   tx_idle_en  = 1'b1;
  bit   rx_idle_en  = 1'b1;
  logic hold_active = 1'b0;
  event hold_off_ev;

  // mirror of the job store and the results it promises
  pwq_pkg::entry_t    job_store [DEPTH];
  int                 job_count = 0;
  pwq_pkg::out_word_t awaited_results [$];

  int mismatch_count = 0;
  int n_pushed = 0, n_dropped = 0, n_dispatched = 0, n_empty_pops = 0, peak_count = 0;

  priority_work_queue #(
    .QUEUE_DEPTH (DEPTH)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #2 clk = ~clk;

  // one line per mismatch, and a tally
  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    mismatch_count++;
    $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
  endtask

  // next result of the queue for one accepted word, updating the mirror
  function automatic pwq_pkg::out_word_t dispatch_result(pwq_pkg::in_word_t w);
    pwq_pkg::out_word_t r;
    int                 best;
    int                 i;
    r = '0;
    if (w.action == pwq_pkg::ACT_PUSH) begin
      if (job_count >= DEPTH) begin
        r.status = pwq_pkg::ST_FULL;
        n_dropped++;
      end else begin
        job_store[job_count] = '{prio: w.job_priority, handle: w.job_handle,
                                 length: w.job_length};
        job_count++;
        n_pushed++;
        if (job_count > peak_count) peak_count = job_count;
      end
    end else if (job_count == 0) begin
      r.status = pwq_pkg::ST_EMPTY;
      n_empty_pops++;
    end else begin
      // highest priority wins, strict compare keeps the earliest arrival
      best = 0;
      for (i = 1; i < job_count; i++)
        if (job_store[i].prio > job_store[best].prio) best = i;
      r.out_handle   = job_store[best].handle;
      r.out_length   = job_store[best].length;
      r.out_priority = job_store[best].prio;
      // later jobs move down one place
      for (i = best; i + 1 < job_count; i++) job_store[i] = job_store[i + 1];
      job_count--;
      n_dispatched++;
    end
    r.pending_count = 5'(job_count);
    return r;
  endfunction

  // compare one result word with the oldest awaited one
  task automatic check_dispatch(pwq_pkg::out_word_t got);
    pwq_pkg::out_word_t want;
    if (awaited_results.size() == 0) begin
      report_mismatch("unexpected result word", got.out_handle, 16'h0);
    end else begin
      want = awaited_results.pop_front();
      if (got.status != want.status)
        report_mismatch("status", 16'(got.status), 16'(want.status));
      if (got.out_handle != want.out_handle)
        report_mismatch("out_handle", got.out_handle, want.out_handle);
      if (got.out_length != want.out_length)
        report_mismatch("out_length", got.out_length, want.out_length);
      if (got.out_priority != want.out_priority)
        report_mismatch("out_priority", 16'(got.out_priority), 16'(want.out_priority));
      if (got.pending_count != want.pending_count)
        report_mismatch("pending_count", 16'(got.pending_count), 16'(want.pending_count));
    end
  endtask

  // receiver: check on handshake, then choose next ready
  always @(posedge clk) begin
    if (out_valid && out_ready) check_dispatch(out_data);
    if (hold_active)
      out_ready <= 1'b0;
    else if (rx_idle_en)
      out_ready <= ($urandom_range(99) >= 31);
    else
      out_ready <= 1'b1;
  end

  // long receiver hold-off, counted in cycles
  always begin
    @(hold_off_ev);
    hold_active <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_active <= 1'b0;
  end

  // offer one word and wait for its handshake
  task automatic send_word(pwq_pkg::in_word_t w);
    while (tx_idle_en && $urandom_range(99) < 31) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    awaited_results.push_back(dispatch_result(w));
  endtask

  function automatic pwq_pkg::in_word_t job_word(logic act, logic [7:0] prio,
                                                 logic [15:0] hnd, logic [15:0] len);
    pwq_pkg::in_word_t w;
    w.action       = act;
    w.job_priority = prio;
    w.job_handle   = hnd;
    w.job_length   = len;
    return w;
  endfunction

  // random content, priorities often bunched to force ties
  function automatic pwq_pkg::in_word_t random_word(logic act);
    logic [7:0] prio;
    case ($urandom_range(3))
      0:       prio = 8'($urandom_range(0, 3));
      1:       prio = 8'($urandom_range(252, 255));
      default: prio = 8'($urandom_range(0, 255));
    endcase
    return job_word(act, prio, 16'($urandom), 16'($urandom));
  endfunction

  // stop offering and wait for every awaited result
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  // field extremes, ties, zero length and empty pops
  task automatic test_directed();
    send_word(job_word(pwq_pkg::ACT_POP,  8'd0,   16'h0000, 16'h0000));
    send_word(job_word(pwq_pkg::ACT_PUSH, 8'd0,   16'h0000, 16'h0000));
    send_word(job_word(pwq_pkg::ACT_PUSH, 8'd255, 16'hffff, 16'hffff));
    send_word(job_word(pwq_pkg::ACT_PUSH, 8'd255, 16'h1234, 16'h0001));
    send_word(job_word(pwq_pkg::ACT_PUSH, 8'd0,   16'ha5a5, 16'h5a5a));
    send_word(job_word(pwq_pkg::ACT_PUSH, 8'd128, 16'h8000, 16'h7fff));
    send_word(job_word(pwq_pkg::ACT_POP,  8'd255, 16'hffff, 16'hffff));
    send_word(job_word(pwq_pkg::ACT_POP,  8'd0,   16'h0000, 16'h0000));
    send_word(job_word(pwq_pkg::ACT_POP,  8'd170, 16'h5555, 16'haaaa));
    send_word(job_word(pwq_pkg::ACT_POP,  8'd0,   16'h0000, 16'h0000));
    send_word(job_word(pwq_pkg::ACT_POP,  8'd0,   16'h0000, 16'h0000));
    send_word(job_word(pwq_pkg::ACT_POP,  8'd255, 16'hffff, 16'hffff));
    // equal priorities come out in arrival order
    send_word(job_word(pwq_pkg::ACT_PUSH, 8'd7,   16'h0101, 16'h0010));
    send_word(job_word(pwq_pkg::ACT_PUSH, 8'd7,   16'h0202, 16'h0020));
    send_word(job_word(pwq_pkg::ACT_PUSH, 8'd7,   16'h0303, 16'h0030));
    send_word(job_word(pwq_pkg::ACT_POP,  8'd0,   16'h0000, 16'h0000));
    // winner at the tail needs no shift
    send_word(job_word(pwq_pkg::ACT_PUSH, 8'd9,   16'h0404, 16'h0040));
    send_word(job_word(pwq_pkg::ACT_POP,  8'd0,   16'h0000, 16'h0000));
    send_word(job_word(pwq_pkg::ACT_POP,  8'd0,   16'h0000, 16'h0000));
    send_word(job_word(pwq_pkg::ACT_POP,  8'd0,   16'h0000, 16'h0000));
    send_word(job_word(pwq_pkg::ACT_POP,  8'd0,   16'h0000, 16'h0000));
    wait_drained();
  endtask

  // fill past full, then drain past empty
  task automatic test_fill_and_drain();
    int k;
    for (k = 0; k < DEPTH + 2; k++) send_word(random_word(pwq_pkg::ACT_PUSH));
    for (k = 0; k < DEPTH + 1; k++) send_word(random_word(pwq_pkg::ACT_POP));
    wait_drained();
  endtask

  // bursts with shifting push/pop balance so the fill level sweeps
  task automatic test_random_mix(int n_items);
    int sent;
    int burst;
    int push_pct;
    int k;
    sent = 0;
    while (sent < n_items) begin
      burst = $urandom_range(10, 60);
      case ($urandom_range(2))
        0:       push_pct = 25;
        1:       push_pct = 50;
        default: push_pct = 80;
      endcase
      for (k = 0; k < burst && sent < n_items; k++) begin
        send_word(random_word(($urandom_range(99) < push_pct) ?
                              pwq_pkg::ACT_PUSH : pwq_pkg::ACT_POP));
        sent++;
      end
    end
    wait_drained();
  endtask

  // both sides at full rate
  task automatic test_no_idle(int n_items);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    test_random_mix(n_items);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  // receiver holds off while words keep coming, input must stall
  task automatic test_backpressure();
    int k;
    tx_idle_en = 1'b0;
    -> hold_off_ev;
    for (k = 0; k < 40; k++)
      send_word(random_word(($urandom_range(1)) ? pwq_pkg::ACT_PUSH : pwq_pkg::ACT_POP));
    tx_idle_en = 1'b1;
    wait_drained();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_fill_and_drain();
    test_no_idle(300);
    test_backpressure();
    test_random_mix(1350);
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("covered %0d stored jobs, %0d dispatched, %0d dropped when full,",
             n_pushed, n_dispatched, n_dropped);
    $display("%0d pops on an empty queue, fill level up to %0d of %0d",
             n_empty_pops, peak_count, DEPTH);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(4_000_000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// File: files.f
design/pwq_pkg.sv
design/pwq_ram.sv
design/priority_work_queue.sv
tb/tb_top.sv
